### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/mqm_pkg.sv
package mqm_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_QUEUES = 4;
	localparam int TIME_BITS = 16;

	localparam int ID_W = 10;
	localparam int LT_IN_W = 16;
	localparam int CNT_OUT_W = 5;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int QID_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int WORD_W = ID_W + TIME_BITS;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_POP    = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic walk_start;
		logic search;
		logic snap;
		logic del_end;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_search;
		logic walk_done;
	} dp_stat_t;
endpackage

### sv/mqm_ctrl.sv
`include "assert_macros.svh"

module mqm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_stall,
	input  mqm_pkg::dp_stat_t stat,
	output logic              in_stall,
	output logic              out_valid,
	output mqm_pkg::cmd_t     cmd
);
	import mqm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_SEARCH = 5'b00100,
		S_SNAP   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.walk_start = 1'b1;
				state_d = stat.need_search ? S_SEARCH : S_SNAP;
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.walk_done) begin
					cmd.del_end = 1'b1;
					cmd.walk_start = 1'b1;
					state_d = S_SNAP;
				end
			end
			S_SNAP: begin
				cmd.snap = 1'b1;
				if (stat.walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_load_free, clk, arst_n, cmd.load_out |-> out_free, "result loaded over a held result")
	`ASSERT_CLK(a_accept_exec, clk, arst_n, cmd.accept |=> state_q == S_EXEC, "accepted request not executed")
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid_q && out_stall |=> out_valid_q, "held result dropped")
endmodule

### sv/mqm_dp.sv
`include "assert_macros.svh"

module mqm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mqm_pkg::cmd_t                     cmd,
	output mqm_pkg::dp_stat_t                 stat,
	input  logic [1:0]                        req_type,
	input  logic [1:0]                        queue_sel,
	input  logic [mqm_pkg::ID_W-1:0]          entry_id,
	input  logic [mqm_pkg::LT_IN_W-1:0]       load_time,
	output logic [1:0]                        status,
	output logic [mqm_pkg::CNT_OUT_W-1:0]     entry_count,
	output logic [mqm_pkg::ID_W-1:0]          head_id,
	output logic [mqm_pkg::LT_IN_W-1:0]       head_load_time,
	output logic [mqm_pkg::ID_W-1:0]          second_id,
	output logic [mqm_pkg::ID_W-1:0]          min_id,
	output logic                              min_valid
);
	import mqm_pkg::*;

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s >= SUM_W'(QUEUE_DEPTH)) begin
			s = s - SUM_W'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	function automatic logic [QID_W-1:0] queue_of(input logic [1:0] sel);
		logic [2:0] v;
		v = {1'b0, sel};
		for (int i = 0; i < 4; i++) begin
			if (int'(v) >= NUM_QUEUES) begin
				v = v - 3'(NUM_QUEUES);
			end
		end
		return QID_W'(v);
	endfunction

	req_t                 req_q;
	logic [QID_W-1:0]     q_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] lt_q;
	status_t              status_q;

	logic [PTR_W-1:0]     head_q [NUM_QUEUES];
	logic [CNT_W-1:0]     cnt_q [NUM_QUEUES];
	logic [WORD_W-1:0]    mem [MEM_DEPTH];

	logic [WORD_W-1:0]    rd_data_s1;
	logic                 rv_s1;
	logic [CNT_W-1:0]     rv_idx_s1;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 found_q;

	logic [ID_W-1:0]      hd_id_q;
	logic [TIME_BITS-1:0] hd_lt_q;
	logic [ID_W-1:0]      sec_id_q;
	logic [ID_W-1:0]      mn_id_q;
	logic [TIME_BITS-1:0] best_q;

	status_t              out_status_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;
	logic [ID_W-1:0]      out_head_id_q;
	logic [LT_IN_W-1:0]   out_head_lt_q;
	logic [ID_W-1:0]      out_second_q;
	logic [ID_W-1:0]      out_min_id_q;
	logic                 out_min_valid_q;

	logic [PTR_W-1:0]     cur_head;
	logic [CNT_W-1:0]     cur_cnt;
	logic [ADDR_W-1:0]    base;
	logic                 full;
	logic                 empty;
	logic                 rd_go;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [PTR_W-1:0]     wr_slot;
	logic [WORD_W-1:0]    wr_data;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ID_W-1:0]      rd_id;
	logic [TIME_BITS-1:0] rd_lt;
	logic                 id_hit;

	logic [TIME_BITS+LT_IN_W-1:0] lt_in_ext;
	logic [TIME_BITS+LT_IN_W-1:0] lt_out_ext;
	logic [CNT_W+CNT_OUT_W-1:0]   cnt_out_ext;

	assign cur_head = head_q[q_q];
	assign cur_cnt = cnt_q[q_q];
	assign base = ADDR_W'(q_q) * ADDR_W'(QUEUE_DEPTH);
	assign empty = (cur_cnt == '0);
	assign full = (cur_cnt == CNT_W'(QUEUE_DEPTH));
	assign rd_go = (cmd.search || cmd.snap) && (rd_idx_q < cur_cnt);
	assign rd_addr = base + ADDR_W'(wrap_add(cur_head, rd_idx_q));
	assign {rd_id, rd_lt} = rd_data_s1;
	assign id_hit = (rd_id == id_q);

	assign lt_in_ext = {TIME_BITS'(0), load_time};
	assign lt_out_ext = {LT_IN_W'(0), hd_lt_q};
	assign cnt_out_ext = {CNT_OUT_W'(0), cur_cnt};

	always_comb begin
		wr_en = 1'b0;
		wr_slot = '0;
		wr_data = {id_q, lt_q};
		if (cmd.exec && (req_q == REQ_APPEND) && !full) begin
			wr_en = 1'b1;
			wr_slot = wrap_add(cur_head, cur_cnt);
		end else if (cmd.search && rv_s1 && found_q) begin
			wr_en = 1'b1;
			wr_slot = wrap_add(cur_head, rv_idx_s1 - CNT_W'(1));
			wr_data = rd_data_s1;
		end
	end

	assign wr_addr = base + ADDR_W'(wr_slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_go) begin
			rd_data_s1 <= mem[rd_addr];
			rv_idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			rv_s1 <= 1'b0;
			rd_idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			rv_s1 <= rd_go;
			if (cmd.walk_start) begin
				rd_idx_q <= '0;
			end else if (rd_go) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (cmd.exec) begin
				case (req_q)
					REQ_APPEND: begin
						if (!full) begin
							cnt_q[q_q] <= cur_cnt + CNT_W'(1);
						end
					end
					REQ_POP: begin
						if (!empty) begin
							head_q[q_q] <= wrap_add(cur_head, CNT_W'(1));
							cnt_q[q_q] <= cur_cnt - CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.del_end && found_q) begin
				cnt_q[q_q] <= cur_cnt - CNT_W'(1);
			end
			if (cmd.walk_start) begin
				found_q <= 1'b0;
			end else if (cmd.search && rv_s1 && !found_q && id_hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_t'(req_type);
			q_q <= queue_of(queue_sel);
			id_q <= entry_id;
			lt_q <= lt_in_ext[TIME_BITS-1:0];
		end
		if (cmd.exec) begin
			case (req_q)
				REQ_APPEND: status_q <= full ? STAT_FULL : STAT_OK;
				default:    status_q <= empty ? STAT_EMPTY : STAT_OK;
			endcase
		end
		if (cmd.del_end && !found_q) begin
			status_q <= STAT_NOT_FOUND;
		end
		if (cmd.walk_start) begin
			hd_id_q <= '0;
			hd_lt_q <= '0;
			sec_id_q <= '0;
			mn_id_q <= '0;
			best_q <= '0;
		end else if (cmd.snap && rv_s1) begin
			if (rv_idx_s1 == '0) begin
				hd_id_q <= rd_id;
				hd_lt_q <= rd_lt;
				mn_id_q <= rd_id;
				best_q <= rd_lt;
			end else begin
				if (rv_idx_s1 == CNT_W'(1)) begin
					sec_id_q <= rd_id;
				end
				if (rd_lt < best_q) begin
					best_q <= rd_lt;
					mn_id_q <= rd_id;
				end
			end
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_cnt_q <= cnt_out_ext[CNT_OUT_W-1:0];
			out_head_id_q <= hd_id_q;
			out_head_lt_q <= lt_out_ext[LT_IN_W-1:0];
			out_second_q <= sec_id_q;
			out_min_id_q <= mn_id_q;
			out_min_valid_q <= !empty;
		end
	end

	assign stat.need_search = (req_q == REQ_DELETE) && !empty;
	assign stat.walk_done = (rd_idx_q >= cur_cnt) && !rv_s1;

	assign status = out_status_q;
	assign entry_count = out_cnt_q;
	assign head_id = out_head_id_q;
	assign head_load_time = out_head_lt_q;
	assign second_id = out_second_q;
	assign min_id = out_min_id_q;
	assign min_valid = out_min_valid_q;

	`ASSERT_CLK(a_cnt_bound, clk, arst_n, cmd.exec |-> cur_cnt <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
	`ASSERT_CLK(a_rd_range, clk, arst_n, rv_s1 |-> rv_idx_s1 < cur_cnt, "read beyond queue count")
	`ASSERT_CLK(a_snap_no_wr, clk, arst_n, cmd.snap |-> !wr_en, "write during snapshot walk")
endmodule

### sv/multi_queue_with_min_search.sv
// Four FIFO queues of entries (id, load time) with delete by id and a
// least-load-time search, kept in one shared memory.
// The request channel (in_valid, in_stall) carries req_type, queue_sel,
// entry_id and load_time: append, pop head, delete by id, or query only.
// The result channel (out_valid, out_stall) returns exactly one result per
// request: status, entry_count, head_id, head_load_time, second_id, min_id
// and min_valid, all describing the selected queue after the request.
// One request is worked on at a time. After acceptance, an execute cycle
// is followed by a walk over the queue that reads one entry a cycle from the
// single memory read port, after which the result is loaded for output.
// A delete on a nonempty queue first walks its m entries to find the id
// and close the gap, before the walk that builds the result.
// The next request is accepted in the cycle after the result is loaded,
// even if that result is still held by a stalling receiver; a stall only
// holds the block once a further result is ready behind the held one.
// Reset clears all queue counts and head pointers; the entry memory is not
// cleared, as only entries below a queue's count are ever read.
module multi_queue_with_min_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [1:0]  queue_sel,
	input  logic [9:0]  entry_id,
	input  logic [15:0] load_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [4:0]  entry_count,
	output logic [9:0]  head_id,
	output logic [15:0] head_load_time,
	output logic [9:0]  second_id,
	output logic [9:0]  min_id,
	output logic        min_valid
);
	import mqm_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	mqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	mqm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req_type),
		.queue_sel      (queue_sel),
		.entry_id       (entry_id),
		.load_time      (load_time),
		.status         (status),
		.entry_count    (entry_count),
		.head_id        (head_id),
		.head_load_time (head_load_time),
		.second_id      (second_id),
		.min_id         (min_id),
		.min_valid      (min_valid)
	);
endmodule

### bench/multi_queue_with_min_search_test.sv
`timescale 1ns / 1ps

module multi_queue_with_min_search_test;
	import mqm_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		status_t                 stat;
		logic [CNT_OUT_W-1:0]    count;
		logic [ID_W-1:0]         head;
		logic [TIME_BITS-1:0]    head_lt;
		logic [ID_W-1:0]         second;
		logic [ID_W-1:0]         least_id;
		logic                    least_valid;
	} snapshot_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = 2'd0;
	logic [1:0]  queue_sel = 2'd0;
	logic [9:0]  entry_id = 10'd0;
	logic [15:0] load_time = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [4:0]  entry_count;
	logic [9:0]  head_id;
	logic [15:0] head_load_time;
	logic [9:0]  second_id;
	logic [9:0]  min_id;
	logic        min_valid;

	logic [ID_W-1:0]      queue_ids [NUM_QUEUES][QUEUE_DEPTH];
	logic [TIME_BITS-1:0] queue_lts [NUM_QUEUES][QUEUE_DEPTH];
	int                   queue_fill [NUM_QUEUES] = '{default: 0};

	snapshot_t pending_snapshots[$];
	int        failures = 0;
	int        sent = 0;
	int        checked = 0;
	int        status_seen [4] = '{default: 0};
	int        snd_idle_pct = 0;
	int        rcv_stall_pct = 0;
	logic      long_hold = 1'b0;
	int        hold_count = 0;
	int        quiet_cycles = 0;

	multi_queue_with_min_search DUT (.*);

	always #5 clk = ~clk;

	// Applies one request to the local copy of the queues and returns the
	// snapshot of the selected queue that the block must answer with.
	function automatic snapshot_t predict_snapshot(req_t kind, logic [1:0] sel,
			logic [ID_W-1:0] id, logic [TIME_BITS-1:0] lt);
		snapshot_t            snap;
		int                   q;
		int                   n;
		int                   gap;
		int                   i;
		logic [TIME_BITS-1:0] least;
		q = int'(sel) % NUM_QUEUES;
		n = queue_fill[q];
		gap = -1;
		snap = '0;
		snap.stat = STAT_OK;
		case (kind)
			REQ_APPEND: begin
				if (n >= QUEUE_DEPTH) begin
					snap.stat = STAT_FULL;
				end else begin
					queue_ids[q][n] = id;
					queue_lts[q][n] = lt;
					n++;
				end
			end
			REQ_POP: begin
				if (n == 0)
					snap.stat = STAT_EMPTY;
				else
					gap = 0;
			end
			REQ_DELETE: begin
				if (n == 0) begin
					snap.stat = STAT_EMPTY;
				end else begin
					for (i = n - 1; i >= 0; i--)
						if (queue_ids[q][i] == id)
							gap = i;
					if (gap < 0)
						snap.stat = STAT_NOT_FOUND;
				end
			end
			default: begin
				if (n == 0)
					snap.stat = STAT_EMPTY;
			end
		endcase
		if (gap >= 0) begin
			for (i = gap; i < n - 1; i++) begin
				queue_ids[q][i] = queue_ids[q][i + 1];
				queue_lts[q][i] = queue_lts[q][i + 1];
			end
			n--;
		end
		queue_fill[q] = n;
		snap.count = CNT_OUT_W'(n);
		if (n > 0) begin
			snap.head = queue_ids[q][0];
			snap.head_lt = queue_lts[q][0];
			if (n > 1)
				snap.second = queue_ids[q][1];
			least = queue_lts[q][0];
			snap.least_id = queue_ids[q][0];
			for (i = 1; i < n; i++) begin
				if (queue_lts[q][i] < least) begin
					least = queue_lts[q][i];
					snap.least_id = queue_ids[q][i];
				end
			end
			snap.least_valid = 1'b1;
		end
		status_seen[snap.stat]++;
		return snap;
	endfunction

	task automatic send_request(input req_t kind, input logic [1:0] sel,
			input logic [9:0] id, input logic [15:0] lt);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		queue_sel <= sel;
		entry_id <= id;
		load_time <= lt;
		do @(posedge clk); while (in_stall);
		pending_snapshots.push_back(predict_snapshot(kind, sel, id, lt));
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_snapshots.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			failures++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		snapshot_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_snapshots.size() == 0) begin
					failures++;
					$error("Result arrived with no request waiting for it.");
				end else begin
					want = pending_snapshots.pop_front();
					checked++;
					check_field("status", want.stat, status);
					check_field("entry_count", want.count, entry_count);
					check_field("head_id", want.head, head_id);
					check_field("head_load_time", want.head_lt, head_load_time);
					check_field("second_id", want.second, second_id);
					check_field("min_id", want.least_id, min_id);
					check_field("min_valid", want.least_valid, min_valid);
				end
			end
			if (!long_hold)
				hold_count = 0;
			if (long_hold && hold_count < HOLD_CYCLES) begin
				out_stall <= 1'b1;
				hold_count++;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: nothing moved on either channel for %0d cycles.",
				WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_empty_queues();
		send_request(REQ_QUERY, 2'd0, 10'd0, 16'd0);
		send_request(REQ_POP, 2'd0, 10'd0, 16'd0);
		send_request(REQ_DELETE, 2'd0, 10'h3FF, 16'hFFFF);
		send_request(REQ_QUERY, 2'd3, 10'h3FF, 16'hFFFF);
		wait_drained();
	endtask

	task automatic test_extremes_and_ties();
		send_request(REQ_APPEND, 2'd1, 10'h3FF, 16'hFFFF);
		send_request(REQ_APPEND, 2'd1, 10'd0, 16'd0);
		send_request(REQ_APPEND, 2'd1, 10'h3FF, 16'd0);
		send_request(REQ_QUERY, 2'd1, 10'd0, 16'd0);
		send_request(REQ_DELETE, 2'd1, 10'h3FF, 16'd0);
		send_request(REQ_DELETE, 2'd1, 10'd555, 16'd0);
		send_request(REQ_POP, 2'd1, 10'd0, 16'd0);
		send_request(REQ_POP, 2'd1, 10'd0, 16'd0);
		send_request(REQ_POP, 2'd1, 10'd0, 16'd0);
		wait_drained();
	endtask

	task automatic test_lone_entry_delete();
		send_request(REQ_APPEND, 2'd2, 10'd5, 16'd100);
		send_request(REQ_DELETE, 2'd2, 10'd6, 16'd0);
		send_request(REQ_DELETE, 2'd2, 10'd5, 16'd0);
		wait_drained();
	endtask

	// The receiver holds off while one queue is filled past its depth, so
	// the block backs up and stalls its request side.
	task automatic test_fill_under_stall();
		int k;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		long_hold <= 1'b1;
		for (k = 0; k < QUEUE_DEPTH; k++)
			send_request(REQ_APPEND, 2'd3, 10'($urandom_range(1023)), 16'($urandom));
		send_request(REQ_APPEND, 2'd3, 10'd1, 16'd1);
		send_request(REQ_QUERY, 2'd3, 10'd0, 16'd0);
		send_request(REQ_DELETE, 2'd3, queue_ids[3][7], 16'd0);
		wait_drained();
		long_hold <= 1'b0;
	endtask

	task automatic test_random_traffic(input int items, input int snd_pct,
			input int rcv_pct);
		int              k;
		int              q;
		int              n;
		int              roll;
		int              append_pct;
		req_t            kind;
		logic [9:0]      id;
		logic [15:0]     lt;
		snd_idle_pct = snd_pct;
		rcv_stall_pct = rcv_pct;
		append_pct = 50;
		for (k = 0; k < items; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(2))
					0: append_pct = 25;
					1: append_pct = 50;
					default: append_pct = 80;
				endcase
			end
			q = $urandom_range(3);
			n = queue_fill[q];
			id = ($urandom_range(3) == 0) ? 10'($urandom_range(7)) : 10'($urandom_range(1023));
			case ($urandom_range(3))
				0: lt = 16'($urandom_range(7));
				1: lt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				default: lt = 16'($urandom);
			endcase
			roll = $urandom_range(99);
			if (roll < append_pct) begin
				kind = REQ_APPEND;
			end else begin
				roll = $urandom_range(99);
				if (roll < 30) begin
					kind = REQ_POP;
				end else if (roll < 75) begin
					kind = REQ_DELETE;
					if (n > 0 && $urandom_range(4) != 0)
						id = queue_ids[q][$urandom_range(n - 1)];
				end else begin
					kind = REQ_QUERY;
				end
			end
			send_request(kind, 2'(q), id, lt);
		end
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queues();
		test_extremes_and_ties();
		test_lone_entry_delete();
		test_fill_under_stall();
		test_random_traffic(580, 9, 88);
		test_random_traffic(580, 88, 9);
		test_random_traffic(580, 0, 0);
		repeat (60) @(posedge clk);
		if (pending_snapshots.size() != 0) begin
			failures++;
			$error("%0d results never arrived.", pending_snapshots.size());
		end
		$display("Sent %0d requests over four queues and checked %0d results.", sent, checked);
		$display("Statuses seen: ok %0d, empty %0d, full %0d, id not found %0d.",
			status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
			status_seen[STAT_NOT_FOUND]);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

### files.f
+incdir+sv
sv/mqm_pkg.sv
sv/mqm_ctrl.sv
sv/mqm_dp.sv
sv/multi_queue_with_min_search.sv
bench/multi_queue_with_min_search_test.sv
